/* rtl/eight_zone_midpoint_line_defines.svh */
// assertion macros for the eight-zone midpoint line rasterizer
`ifndef EIGHT_ZONE_MIDPOINT_LINE_DEFINES_SVH
`define EIGHT_ZONE_MIDPOINT_LINE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define EZML_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ezml same-cycle check failed");

// next-cycle implication
`define EZML_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ezml next-cycle check failed");

`endif

/* rtl/ezml_pkg.sv */
// shared types, constants and the zone colour table
`timescale 1ns / 1ps

package ezml_pkg;

    localparam int COORD_BITS  = 12;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int DEC_BITS    = COORD_BITS + 4;
    localparam int STEP_BITS   = COORD_BITS + 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [2:0] ZONE_0 = 3'd0;
    localparam logic [2:0] ZONE_1 = 3'd1;
    localparam logic [2:0] ZONE_2 = 3'd2;
    localparam logic [2:0] ZONE_3 = 3'd3;
    localparam logic [2:0] ZONE_4 = 3'd4;
    localparam logic [2:0] ZONE_5 = 3'd5;
    localparam logic [2:0] ZONE_6 = 3'd6;
    localparam logic [2:0] ZONE_7 = 3'd7;

    localparam logic [7:0] COLOR_FULL = 8'd255;
    localparam logic [7:0] COLOR_GREY = 8'd105;
    localparam logic [7:0] COLOR_NONE = 8'd0;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [DEC_BITS-1:0]   dec_t;
    typedef logic signed [STEP_BITS-1:0]  step_t;

    // most negative code and the value it is clamped to
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam coord_t COORD_LIM = {1'b1, {(COORD_BITS-2){1'b0}}, 1'b1};

    // one classified command as it travels from front to back
    typedef struct packed {
        logic       cmd;
        logic [2:0] zone;
        coord_t     fx0;
        coord_t     fy0;
        coord_t     fx1;
        diff_t      fdx;
        diff_t      fdy;
    } entry_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [QCNT_BITS-1:0] count;
    } queue_status_t;

    typedef struct packed {
        logic pop;
        logic active;
        logic emit_last;
    } back_status_t;

    function automatic rgb_t zone_rgb(input logic [2:0] z);
        rgb_t c;
        unique case (z)
            ZONE_0:  c = '{COLOR_FULL, COLOR_NONE, COLOR_NONE};
            ZONE_1:  c = '{COLOR_NONE, COLOR_FULL, COLOR_NONE};
            ZONE_2:  c = '{COLOR_NONE, COLOR_NONE, COLOR_FULL};
            ZONE_3:  c = '{COLOR_FULL, COLOR_FULL, COLOR_NONE};
            ZONE_4:  c = '{COLOR_FULL, COLOR_NONE, COLOR_FULL};
            ZONE_5:  c = '{COLOR_NONE, COLOR_FULL, COLOR_FULL};
            ZONE_6:  c = '{COLOR_GREY, COLOR_GREY, COLOR_GREY};
            default: c = '{COLOR_FULL, COLOR_FULL, COLOR_FULL};
        endcase
        return c;
    endfunction

endpackage

/* rtl/eight_zone_midpoint_line.sv */
// top level of the eight-zone midpoint line rasterizer
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   cmd, start_x, start_y, end_x, end_y
//   out      output     out_valid / out_stall pixel_x, pixel_y, zone, red, green, blue, last
//
// one command beat per cycle while in_stall is low; a step beat on an active line gives a pixel
// after it is taken, by way of the four-entry command queue's head register and then the output register
// a load sets up the walker and gives no beat; a step with no line is dropped
// the walker's decision add and compare produce one pixel per cycle while the output register is free
// out_stall holds the output register, the queue fills, then in_stall rises when it is full
// reset clears the queue, the active flag and out_valid; no line is active after reset
`timescale 1ns / 1ps
`include "eight_zone_midpoint_line_defines.svh"

module eight_zone_midpoint_line
    import ezml_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  coord_t     start_x,
    input  coord_t     start_y,
    input  coord_t     end_x,
    input  coord_t     end_y,
    output logic       out_valid,
    input  logic       out_stall,
    output coord_t     pixel_x,
    output coord_t     pixel_y,
    output logic [2:0] zone,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       last
);

    entry_t        front_entry;
    entry_t        head;
    queue_status_t q_status;
    back_status_t  b_status;
    logic          push;

    assign in_stall = q_status.full;
    assign push     = in_valid && !in_stall;

    ezml_front u_front (
        .cmd     (cmd),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .entry   (front_entry)
    );

    ezml_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .pop        (b_status.pop),
        .head       (head),
        .status     (q_status)
    );

    ezml_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_empty (q_status.empty),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .zone        (zone),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last        (last),
        .status      (b_status)
    );

    // queue never overfills and is never read empty
    `EZML_ASSERT_NOW(a_queue_bound, 1'b1, q_status.count <= QCNT_BITS'(QUEUE_DEPTH))
    `EZML_ASSERT_NOW(a_pop_nonempty, b_status.pop, !q_status.empty)
    // the final pixel ends the line and shows up flagged on the output
    `EZML_ASSERT_NEXT(a_last_ends_line, b_status.emit_last, !b_status.active && out_valid && last)
    // a step beat on a live line always produces a beat
    `EZML_ASSERT_NEXT(a_step_emits, b_status.pop && head.cmd == CMD_STEP && b_status.active, out_valid)

endmodule

/* rtl/ezml_front.sv */
// front end: clamps endpoints, picks the zone and folds the line into zone 0
`timescale 1ns / 1ps

module ezml_front
    import ezml_pkg::*;
(
    input  logic   cmd,
    input  coord_t start_x,
    input  coord_t start_y,
    input  coord_t end_x,
    input  coord_t end_y,
    output entry_t entry
);

    function automatic coord_t clamp_coord(input coord_t v);
        return (v == COORD_MIN) ? COORD_LIM : v;
    endfunction

    coord_t     x0;
    coord_t     y0;
    coord_t     x1;
    coord_t     y1;
    diff_t      dx;
    diff_t      dy;
    diff_t      ax;
    diff_t      ay;
    logic       x_major;
    logic [2:0] zone_sel;

    always_comb
    begin
        x0 = clamp_coord(start_x);
        y0 = clamp_coord(start_y);
        x1 = clamp_coord(end_x);
        y1 = clamp_coord(end_y);
        dx = diff_t'(x1) - diff_t'(x0);
        dy = diff_t'(y1) - diff_t'(y0);
        ax = dx[DIFF_BITS-1] ? -dx : dx;
        ay = dy[DIFF_BITS-1] ? -dy : dy;
        x_major = (ax >= ay);

        unique case ({x_major, dx[DIFF_BITS-1], dy[DIFF_BITS-1]})
            3'b100:  zone_sel = ZONE_0;
            3'b101:  zone_sel = ZONE_7;
            3'b110:  zone_sel = ZONE_3;
            3'b111:  zone_sel = ZONE_4;
            3'b000:  zone_sel = ZONE_1;
            3'b001:  zone_sel = ZONE_6;
            3'b010:  zone_sel = ZONE_2;
            default: zone_sel = ZONE_5;
        endcase

        entry.cmd  = cmd;
        entry.zone = zone_sel;
        // folded deltas are just the major and minor magnitudes
        entry.fdx  = x_major ? ax : ay;
        entry.fdy  = x_major ? ay : ax;

        unique case (zone_sel)
            ZONE_0:
            begin
                entry.fx0 = x0;  entry.fy0 = y0;  entry.fx1 = x1;
            end
            ZONE_1:
            begin
                entry.fx0 = y0;  entry.fy0 = x0;  entry.fx1 = y1;
            end
            ZONE_2:
            begin
                entry.fx0 = y0;  entry.fy0 = -x0; entry.fx1 = y1;
            end
            ZONE_3:
            begin
                entry.fx0 = -x0; entry.fy0 = y0;  entry.fx1 = -x1;
            end
            ZONE_4:
            begin
                entry.fx0 = -x0; entry.fy0 = -y0; entry.fx1 = -x1;
            end
            ZONE_5:
            begin
                entry.fx0 = -y0; entry.fy0 = -x0; entry.fx1 = -y1;
            end
            ZONE_6:
            begin
                entry.fx0 = -y0; entry.fy0 = x0;  entry.fx1 = -y1;
            end
            default:
            begin
                entry.fx0 = x0;  entry.fy0 = -y0; entry.fx1 = x1;
            end
        endcase
    end

endmodule

/* rtl/ezml_queue.sv */
// short command queue between the front end and the line walker
`timescale 1ns / 1ps

module ezml_queue
    import ezml_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  entry_t        push_entry,
    input  logic          pop,
    output entry_t        head,
    output queue_status_t status
);

    entry_t               mem_reg [QUEUE_DEPTH];
    entry_t               head_reg;
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_BITS'(1);
            2'b01:   count_next = count_reg - QCNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
        // fetch the next head entry, forwarding a beat written into that slot now
        if (push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= push_entry;
        end
        else
        begin
            head_reg <= mem_reg[rd_ptr_next];
        end
    end

    assign head         = head_reg;
    assign status.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

/* rtl/ezml_back.sv */
// back end: midpoint walker, unfolding into the line's zone, output register
`timescale 1ns / 1ps

module ezml_back
    import ezml_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  entry_t       head,
    input  logic         queue_empty,
    input  logic         out_stall,
    output logic         out_valid,
    output coord_t       pixel_x,
    output coord_t       pixel_y,
    output logic [2:0]   zone,
    output logic [7:0]   red,
    output logic [7:0]   green,
    output logic [7:0]   blue,
    output logic         last,
    output back_status_t status
);

    logic       active_reg;
    logic       active_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    coord_t     walk_x_reg;
    coord_t     walk_x_next;
    coord_t     walk_y_reg;
    coord_t     walk_y_next;
    coord_t     stop_x_reg;
    coord_t     stop_x_next;
    dec_t       decision_reg;
    dec_t       decision_next;
    step_t      step_east_reg;
    step_t      step_east_next;
    step_t      step_ne_reg;
    step_t      step_ne_next;
    logic [2:0] zone_reg;
    logic [2:0] zone_next;
    coord_t     pixel_x_reg;
    coord_t     pixel_y_reg;
    logic [2:0] out_zone_reg;
    rgb_t       rgb_reg;
    logic       last_reg;

    logic   out_free;
    logic   is_load;
    logic   pop;
    logic   emit;
    logic   fin;
    coord_t px;
    coord_t py;
    dec_t   fdx_d;
    dec_t   fdy_d;
    step_t  fdx_s;
    step_t  fdy_s;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        is_load  = (head.cmd == CMD_LOAD);
        // a step with no line is dropped; a pixel step waits for the output slot
        pop      = !queue_empty && (is_load || !active_reg || out_free);
        emit     = pop && !is_load && active_reg;
        fin      = (walk_x_reg >= stop_x_reg);

        fdx_d = dec_t'(head.fdx);
        fdy_d = dec_t'(head.fdy);
        fdx_s = step_t'(head.fdx);
        fdy_s = step_t'(head.fdy);

        active_next   = active_reg;
        walk_x_next   = walk_x_reg;
        walk_y_next   = walk_y_reg;
        stop_x_next   = stop_x_reg;
        decision_next = decision_reg;
        step_east_next = step_east_reg;
        step_ne_next  = step_ne_reg;
        zone_next     = zone_reg;

        if (pop && is_load)
        begin
            active_next    = 1'b1;
            walk_x_next    = head.fx0;
            walk_y_next    = head.fy0;
            stop_x_next    = head.fx1;
            decision_next  = (fdy_d <<< 1) - fdx_d;
            step_east_next = fdy_s <<< 1;
            step_ne_next   = (fdy_s - fdx_s) <<< 1;
            zone_next      = head.zone;
        end
        else if (emit)
        begin
            if (fin)
            begin
                active_next = 1'b0;
            end
            else
            begin
                walk_x_next = walk_x_reg + coord_t'(1);
                if (decision_reg[DEC_BITS-1])
                begin
                    decision_next = decision_reg + dec_t'(step_east_reg);
                end
                else
                begin
                    decision_next = decision_reg + dec_t'(step_ne_reg);
                    walk_y_next   = walk_y_reg + coord_t'(1);
                end
            end
        end

        unique case (zone_reg)
            ZONE_0:  begin px = walk_x_reg;  py = walk_y_reg;  end
            ZONE_1:  begin px = walk_y_reg;  py = walk_x_reg;  end
            ZONE_2:  begin px = -walk_y_reg; py = walk_x_reg;  end
            ZONE_3:  begin px = -walk_x_reg; py = walk_y_reg;  end
            ZONE_4:  begin px = -walk_x_reg; py = -walk_y_reg; end
            ZONE_5:  begin px = -walk_y_reg; py = -walk_x_reg; end
            ZONE_6:  begin px = walk_y_reg;  py = -walk_x_reg; end
            default: begin px = walk_x_reg;  py = -walk_y_reg; end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            zone_reg      <= ZONE_0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            zone_reg      <= zone_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_x_reg    <= walk_x_next;
        walk_y_reg    <= walk_y_next;
        stop_x_reg    <= stop_x_next;
        decision_reg  <= decision_next;
        step_east_reg <= step_east_next;
        step_ne_reg   <= step_ne_next;
        if (emit)
        begin
            pixel_x_reg  <= px;
            pixel_y_reg  <= py;
            out_zone_reg <= zone_reg;
            rgb_reg      <= zone_rgb(zone_reg);
            last_reg     <= fin;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pixel_x          = pixel_x_reg;
    assign pixel_y          = pixel_y_reg;
    assign zone             = out_zone_reg;
    assign red              = rgb_reg.red;
    assign green            = rgb_reg.green;
    assign blue             = rgb_reg.blue;
    assign last             = last_reg;
    assign status.pop       = pop;
    assign status.active    = active_reg;
    assign status.emit_last = emit && fin;

endmodule

/* verif/eight_zone_midpoint_line_tb.sv */
// self-checking testbench for the eight-zone midpoint line rasterizer
`timescale 1ns / 1ps

module eight_zone_midpoint_line_tb;
    import ezml_pkg::*;

    localparam int ITEM_TARGET  = 1150;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int CMAX         = 2 ** (COORD_BITS - 1) - 1;

    typedef struct packed {
        coord_t     px;
        coord_t     py;
        logic [2:0] zone;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       cmd;
    coord_t     start_x;
    coord_t     start_y;
    coord_t     end_x;
    coord_t     end_y;
    logic       out_valid;
    logic       out_stall;
    coord_t     pixel_x;
    coord_t     pixel_y;
    logic [2:0] zone;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;

    // predicted walker state, kept in folded coordinates
    logic       ln_active;
    coord_t     ln_walk_x;
    coord_t     ln_walk_y;
    coord_t     ln_stop_x;
    dec_t       ln_decision;
    step_t      ln_step_e;
    step_t      ln_step_ne;
    logic [2:0] ln_zone;

    pixel_t pixel_queue[$];
    int     error_count;
    int     beats_taken;
    int     cycle_count;
    int     hold_cycles;
    bit     tx_idles;
    bit     rx_idles;

    eight_zone_midpoint_line uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .zone      (zone),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // most negative code is clamped so that negation stays in range
    function automatic int sat_coord(coord_t v);
        return (v == COORD_MIN) ? int'(COORD_LIM) : int'(v);
    endfunction

    function automatic int line_pixels(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int dx;
        int dy;
        dx = sat_coord(ex) - sat_coord(sx);
        dy = sat_coord(ey) - sat_coord(sy);
        if (dx < 0)
        begin
            dx = -dx;
        end
        if (dy < 0)
        begin
            dy = -dy;
        end
        return ((dx > dy) ? dx : dy) + 1;
    endfunction

    // c + d, reflected to c - d when it would leave the coordinate range, or left at c if both would
    function automatic coord_t offset(coord_t c, int d);
        int t;
        t = int'(c) + d;
        if (t > CMAX || t < -CMAX - 1)
        begin
            t = int'(c) - d;
        end
        if (t > CMAX || t < -CMAX - 1)
        begin
            t = int'(c);
        end
        return coord_t'(t);
    endfunction

    task automatic rasterize_beat(logic c, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int         x0, y0, x1, y1, dx, dy, ax, ay;
        int         fx0, fy0, fx1, fy1, fdx, fdy;
        int         wx, wy, px, py;
        logic [2:0] z;
        logic [23:0] rgb;
        pixel_t     p;
        if (c == CMD_LOAD)
        begin
            x0 = sat_coord(sx);
            y0 = sat_coord(sy);
            x1 = sat_coord(ex);
            y1 = sat_coord(ey);
            dx = x1 - x0;
            dy = y1 - y0;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            // ties go to the x-major zones
            if (ax >= ay)
            begin
                z = (dx >= 0) ? ((dy >= 0) ? ZONE_0 : ZONE_7) : ((dy >= 0) ? ZONE_3 : ZONE_4);
            end
            else
            begin
                z = (dx >= 0) ? ((dy >= 0) ? ZONE_1 : ZONE_6) : ((dy >= 0) ? ZONE_2 : ZONE_5);
            end
            case (z)
                ZONE_0:  begin fx0 = x0;  fy0 = y0;  fx1 = x1;  fy1 = y1;  end
                ZONE_1:  begin fx0 = y0;  fy0 = x0;  fx1 = y1;  fy1 = x1;  end
                ZONE_2:  begin fx0 = y0;  fy0 = -x0; fx1 = y1;  fy1 = -x1; end
                ZONE_3:  begin fx0 = -x0; fy0 = y0;  fx1 = -x1; fy1 = y1;  end
                ZONE_4:  begin fx0 = -x0; fy0 = -y0; fx1 = -x1; fy1 = -y1; end
                ZONE_5:  begin fx0 = -y0; fy0 = -x0; fx1 = -y1; fy1 = -x1; end
                ZONE_6:  begin fx0 = -y0; fy0 = x0;  fx1 = -y1; fy1 = x1;  end
                default: begin fx0 = x0;  fy0 = -y0; fx1 = x1;  fy1 = -y1; end
            endcase
            fdx = fx1 - fx0;
            fdy = fy1 - fy0;
            ln_walk_x   = coord_t'(fx0);
            ln_walk_y   = coord_t'(fy0);
            ln_stop_x   = coord_t'(fx1);
            ln_decision = dec_t'(2 * fdy - fdx);
            ln_step_e   = step_t'(2 * fdy);
            ln_step_ne  = step_t'(2 * (fdy - fdx));
            ln_zone     = z;
            ln_active   = 1'b1;
            beats_taken++;
        end
        else if (ln_active)
        begin
            wx = int'(ln_walk_x);
            wy = int'(ln_walk_y);
            // unfold the walk position back into the line's own zone
            case (ln_zone)
                ZONE_0:
                begin
                    px = wx;  py = wy;  rgb = {COLOR_FULL, COLOR_NONE, COLOR_NONE};
                end
                ZONE_1:
                begin
                    px = wy;  py = wx;  rgb = {COLOR_NONE, COLOR_FULL, COLOR_NONE};
                end
                ZONE_2:
                begin
                    px = -wy; py = wx;  rgb = {COLOR_NONE, COLOR_NONE, COLOR_FULL};
                end
                ZONE_3:
                begin
                    px = -wx; py = wy;  rgb = {COLOR_FULL, COLOR_FULL, COLOR_NONE};
                end
                ZONE_4:
                begin
                    px = -wx; py = -wy; rgb = {COLOR_FULL, COLOR_NONE, COLOR_FULL};
                end
                ZONE_5:
                begin
                    px = -wy; py = -wx; rgb = {COLOR_NONE, COLOR_FULL, COLOR_FULL};
                end
                ZONE_6:
                begin
                    px = wy;  py = -wx; rgb = {COLOR_GREY, COLOR_GREY, COLOR_GREY};
                end
                default:
                begin
                    px = wx;  py = -wy; rgb = {COLOR_FULL, COLOR_FULL, COLOR_FULL};
                end
            endcase
            p.px   = coord_t'(px);
            p.py   = coord_t'(py);
            p.zone = ln_zone;
            {p.red, p.green, p.blue} = rgb;
            p.last = (ln_walk_x >= ln_stop_x);
            pixel_queue.push_back(p);
            beats_taken++;
            if (p.last)
            begin
                ln_active = 1'b0;
            end
            else
            begin
                if (ln_decision < 0)
                begin
                    ln_decision = ln_decision + ln_step_e;
                end
                else
                begin
                    ln_decision = ln_decision + ln_step_ne;
                    ln_walk_y++;
                end
                ln_walk_x++;
            end
        end
    endtask

    task automatic send_beat(logic c, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        @(negedge clk);
        while (tx_idles && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        rasterize_beat(c, sx, sy, ex, ey);
    endtask

    task automatic load_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        send_beat(CMD_LOAD, sx, sy, ex, ey);
    endtask

    // coordinate fields of a step beat are don't-care, so fill them with noise
    task automatic step_line(int n);
        repeat (n)
        begin
            send_beat(CMD_STEP, coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom));
        end
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixel_queue.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        step_line(1);
        load_line(coord_t'(5), coord_t'(-3), coord_t'(5), coord_t'(-3));
        step_line(2);
        load_line(COORD_MIN, COORD_MIN, coord_t'(2047), coord_t'(2047));
        step_line(3);
        // x-major tie, dropped mid-walk by the next load
        load_line(coord_t'(2047), coord_t'(-2047), COORD_MIN, coord_t'(2047));
        step_line(2);
        load_line(coord_t'(0), coord_t'(0), coord_t'(-3), coord_t'(3));
        step_line(5);
        load_line(coord_t'(0), coord_t'(0), coord_t'(2), coord_t'(-5));
        step_line(7);
        wait_drain();
    endtask

    task automatic test_zone_sweep();
        int         maj;
        int         mnr;
        int         dx;
        int         dy;
        logic [2:0] zsel;
        coord_t     sx;
        coord_t     sy;
        for (int z = 0; z < 8; z++)
        begin
            zsel = 3'(z);
            maj  = $urandom_range(2, 12);
            if (zsel == ZONE_0 || zsel == ZONE_3 || zsel == ZONE_4 || zsel == ZONE_7)
            begin
                mnr = $urandom_range(1, maj);
            end
            else
            begin
                mnr = $urandom_range(1, maj - 1);
            end
            case (zsel)
                ZONE_0:  begin dx = maj;  dy = mnr;  end
                ZONE_1:  begin dx = mnr;  dy = maj;  end
                ZONE_2:  begin dx = -mnr; dy = maj;  end
                ZONE_3:  begin dx = -maj; dy = mnr;  end
                ZONE_4:  begin dx = -maj; dy = -mnr; end
                ZONE_5:  begin dx = -mnr; dy = -maj; end
                ZONE_6:  begin dx = mnr;  dy = -maj; end
                default: begin dx = maj;  dy = -mnr; end
            endcase
            sx = coord_t'(int'($urandom_range(0, 4000)) - 2000);
            sy = coord_t'(int'($urandom_range(0, 4000)) - 2000);
            load_line(sx, sy, offset(sx, dx), offset(sy, dy));
            step_line(maj + 2);
        end
    endtask

    // output held off long enough for the queue to fill and stall the input
    task automatic test_output_hold();
        tx_idles    = 1'b0;
        rx_idles    = 1'b0;
        hold_cycles = 80;
        load_line(coord_t'(-10), coord_t'(4), coord_t'(30), coord_t'(20));
        step_line(41);
        wait_drain();
        tx_idles = 1'b1;
        rx_idles = 1'b1;
    endtask

    task automatic run_random_lines(int goal);
        int     kind;
        int     steps;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        while (beats_taken < goal)
        begin
            kind = $urandom_range(99);
            sx   = coord_t'($urandom);
            sy   = coord_t'($urandom);
            if (kind < 6)
            begin
                send_beat($urandom_range(1) ? CMD_STEP : CMD_LOAD, sx, sy,
                          coord_t'($urandom), coord_t'($urandom));
            end
            else
            begin
                if (kind < 12)
                begin
                    ex = coord_t'($urandom);
                    ey = coord_t'($urandom);
                end
                else
                begin
                    ex = offset(sx, int'($urandom_range(0, 30)) - 15);
                    if (kind < 30)
                    begin
                        // diagonal, |dy| equal to |dx|
                        ey = offset(sy, ($urandom_range(1) ? 1 : -1) * (int'(ex) - int'(sx)));
                    end
                    else
                    begin
                        ey = offset(sy, int'($urandom_range(0, 30)) - 15);
                    end
                end
                steps = line_pixels(sx, sy, ex, ey);
                // long lines are cut short by the next load
                if (kind < 12 || $urandom_range(9) == 0)
                begin
                    steps = $urandom_range(0, (steps < 8) ? steps : 8);
                end
                else
                begin
                    steps += $urandom_range(1);
                end
                load_line(sx, sy, ex, ey);
                step_line(steps);
            end
        end
    endtask

    task automatic test_streaming();
        tx_idles = 1'b0;
        rx_idles = 1'b0;
        run_random_lines(beats_taken + 150);
        tx_idles = 1'b1;
        rx_idles = 1'b1;
    endtask

    task automatic test_random();
        run_random_lines(ITEM_TARGET);
    endtask

    // receiver side: random stalls plus the occasional long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= rx_idles && ($urandom_range(99) < 12);
            end
        end
    end

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pixel_x, pixel_y, zone, red, green, blue, last};
            if (pixel_queue.size() == 0)
            begin
                flag_error($sformatf("unexpected pixel (%0d,%0d) zone %0d",
                                     pixel_x, pixel_y, zone));
            end
            else
            begin
                want = pixel_queue.pop_front();
                if (got.px !== want.px || got.py !== want.py || got.zone !== want.zone ||
                    got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.last !== want.last)
                begin
                    flag_error($sformatf(
                        "pixel exp (%0d,%0d) z%0d %0d/%0d/%0d l%0b got (%0d,%0d) z%0d %0d/%0d/%0d l%0b",
                        want.px, want.py, want.zone, want.red, want.green, want.blue, want.last,
                        got.px, got.py, got.zone, got.red, got.green, got.blue, got.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_LOAD;
        start_x     = '0;
        start_y     = '0;
        end_x       = '0;
        end_y       = '0;
        tx_idles    = 1'b1;
        rx_idles    = 1'b1;
        hold_cycles = 0;
        error_count = 0;
        beats_taken = 0;
        cycle_count = 0;
        ln_active   = 1'b0;
        ln_walk_x   = '0;
        ln_walk_y   = '0;
        ln_stop_x   = '0;
        ln_decision = '0;
        ln_step_e   = '0;
        ln_step_ne  = '0;
        ln_zone     = ZONE_0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_zone_sweep();
        test_output_hold();
        test_streaming();
        test_random();

        wait_drain();
        repeat (16) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
